@@ sv/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, off during reset.
`define ASSERT_IMPL(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, off during reset.
`define ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_IMPL(name, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(name, clk, rstn, ante, cons, msg)
`endif
`endif

@@ sv/hsv2rgb_pkg.sv @@
package hsv2rgb_pkg;

  typedef logic [7:0]  level_t;   // one 8-bit channel or level
  typedef logic [2:0]  sext_t;    // hue sextant, 0..6
  typedef logic [10:0] hscale_t;  // hue on the 0..1530 scale

  localparam int HueWidth   = 16;
  localparam int ScaleWidth = HueWidth + 11;  // hue * 1530 + round fits 27 bits
  localparam int HueScale   = 1530;
  localparam int HueRound   = 32768;
  localparam int SextSpan   = 255;
  localparam int LevelMax   = 255;
  localparam int NumBounds  = 6;              // sextant boundaries on the scale

  // Sextant codes; the top of the scale (6) falls into the last ordering.
  localparam sext_t SEXT_RY = 3'd0;  // red to yellow
  localparam sext_t SEXT_YG = 3'd1;  // yellow to green
  localparam sext_t SEXT_GC = 3'd2;  // green to cyan
  localparam sext_t SEXT_CB = 3'd3;  // cyan to blue
  localparam sext_t SEXT_BM = 3'd4;  // blue to magenta
  localparam sext_t SEXT_TOP = 3'd6; // rounded hue of 1530

endpackage

@@ sv/hsv_to_rgb_pixel.sv @@
// Channel  Direction  Handshake           Fields
// in_      in         in_valid/in_stall   hue[15:0], saturation[7:0], brightness[7:0]
// out_     out        out_valid/out_stall red[7:0], green[7:0], blue[7:0]
//
// Five register stages: hue scale, sextant split, cut products, level products,
// channel select. One beat enters per cycle while in_stall is low.
// Each stage holds a valid bit; a stage takes a new beat when it is empty or
// its successor moves, so bubbles close up behind a stalled output.
// rst_n (synchronous) clears the valid bits only; payload is not reset.
`include "assert_macros.svh"

module hsv_to_rgb_pixel
  import hsv2rgb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_hue,
  input  logic [7:0]  in_saturation,
  input  logic [7:0]  in_brightness,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue
);

  // stage valids and ready chain
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5     = !v5_r || !out_stall;
  assign rdy4     = !v4_r || rdy5;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_stall = !rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
    end
  end

  // Stage 1: round hue onto 0..1530
  logic [ScaleWidth-1:0] prod1;
  hscale_t scaled1_nxt, scaled1_r;
  level_t  sat1_r, val1_r;

  assign prod1 = ScaleWidth'(in_hue) * ScaleWidth'(HueScale) + ScaleWidth'(HueRound);
  assign scaled1_nxt = prod1[ScaleWidth-1:HueWidth];

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      scaled1_r <= scaled1_nxt;
      sat1_r    <= in_saturation;
      val1_r    <= in_brightness;
    end
  end

  // Stage 2: sextant by boundary compares, remainder, level p
  sext_t          sext2_nxt, sext2_r;
  level_t         frac2_nxt, frac2_r;
  logic [15:0]    pprod2;
  level_t         p2_nxt, p2_r, sat2_r, val2_r;
  hscale_t        base2;

  always_comb begin
    sext2_nxt = '0;
    for (int k = 1; k <= NumBounds; k++) begin
      if (scaled1_r >= hscale_t'(k * SextSpan)) sext2_nxt = sext2_nxt + sext_t'(1);
    end
  end

  assign base2     = {sext2_nxt, 8'b0} - hscale_t'(sext2_nxt);  // sextant * 255
  assign frac2_nxt = level_t'(scaled1_r - base2);
  assign pprod2    = 16'(val1_r) * 16'(level_t'(LevelMax) - sat1_r);
  assign p2_nxt    = pprod2[15:8];

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      sext2_r <= sext2_nxt;
      frac2_r <= frac2_nxt;
      p2_r    <= p2_nxt;
      sat2_r  <= sat1_r;
      val2_r  <= val1_r;
    end
  end

  // Stage 3: saturation cuts for q and t
  logic [15:0] cqprod3, ctprod3;
  level_t      cq3_r, ct3_r, p3_r, val3_r;
  sext_t       sext3_r;
  logic        grey3_r;

  assign cqprod3 = 16'(sat2_r) * 16'(frac2_r);
  assign ctprod3 = 16'(sat2_r) * 16'(level_t'(LevelMax) - frac2_r);

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      cq3_r   <= cqprod3[15:8];
      ct3_r   <= ctprod3[15:8];
      p3_r    <= p2_r;
      val3_r  <= val2_r;
      sext3_r <= sext2_r;
      grey3_r <= (sat2_r == '0);
    end
  end

  // Stage 4: levels q and t
  logic [15:0] qprod4, tprod4;
  level_t      q4_r, t4_r, p4_r, val4_r;
  sext_t       sext4_r;
  logic        grey4_r;

  assign qprod4 = 16'(val3_r) * 16'(level_t'(LevelMax) - cq3_r);
  assign tprod4 = 16'(val3_r) * 16'(level_t'(LevelMax) - ct3_r);

  always_ff @(posedge clk) begin
    if (rdy4 && v3_r) begin
      q4_r    <= qprod4[15:8];
      t4_r    <= tprod4[15:8];
      p4_r    <= p3_r;
      val4_r  <= val3_r;
      sext4_r <= sext3_r;
      grey4_r <= grey3_r;
    end
  end

  // Stage 5: channel ordering by sextant, grey bypass
  level_t red5_nxt, green5_nxt, blue5_nxt;
  level_t red5_r, green5_r, blue5_r;

  always_comb begin
    case (sext4_r)
      SEXT_RY: begin red5_nxt = val4_r; green5_nxt = t4_r;   blue5_nxt = p4_r;   end
      SEXT_YG: begin red5_nxt = q4_r;   green5_nxt = val4_r; blue5_nxt = p4_r;   end
      SEXT_GC: begin red5_nxt = p4_r;   green5_nxt = val4_r; blue5_nxt = t4_r;   end
      SEXT_CB: begin red5_nxt = p4_r;   green5_nxt = q4_r;   blue5_nxt = val4_r; end
      SEXT_BM: begin red5_nxt = t4_r;   green5_nxt = p4_r;   blue5_nxt = val4_r; end
      default: begin red5_nxt = val4_r; green5_nxt = p4_r;   blue5_nxt = q4_r;   end
    endcase
    if (grey4_r) begin
      red5_nxt   = val4_r;
      green5_nxt = val4_r;
      blue5_nxt  = val4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5 && v4_r) begin
      red5_r   <= red5_nxt;
      green5_r <= green5_nxt;
      blue5_r  <= blue5_nxt;
    end
  end

  assign out_valid = v5_r;
  assign out_red   = red5_r;
  assign out_green = green5_r;
  assign out_blue  = blue5_r;

  // checks
  `ASSERT_IMPL(a_sext_range, clk, rst_n, v2_r, sext2_r <= SEXT_TOP, "sextant above top")
  `ASSERT_IMPL(a_frac_range, clk, rst_n, v2_r, frac2_r != 8'hFF, "remainder out of range")
  `ASSERT_IMPL(a_empty_takes, clk, rst_n, !v1_r, !in_stall, "empty front stage stalls input")
  `ASSERT_NEXT(a_grey_out, clk, rst_n, v4_r && rdy5 && grey4_r, out_red == out_green && out_green == out_blue, "grey beat not equal")
  `ASSERT_NEXT(a_max_chan, clk, rst_n, v4_r && rdy5, out_red == $past(val4_r) || out_green == $past(val4_r) || out_blue == $past(val4_r), "no channel at brightness")

endmodule
